>>> hw/rtl/tvns_pkg.sv
// ============================================================================
// Two-voice note sequencer package
// Shared constants, operation codes and record types for the sequencer and
// its note table memories.
// ============================================================================
package tvns_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int LEVEL_W     = 4;
    localparam int CFG_INDEX_W = 1;
    localparam int NUM_VOICES  = 2;

    localparam logic [LEVEL_W-1:0] MELODY_LEVEL_RST = 4'd12;
    localparam logic [LEVEL_W-1:0] BASS_LEVEL_RST   = 4'd10;

    localparam int VOICE_MELODY = 0;
    localparam int VOICE_BASS   = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_MELODY_LEVEL = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASS_LEVEL   = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_PLAY = 2'd1,
        OP_LOAD = 2'd2,
        OP_STOP = 2'd3
    } op_t;

    typedef struct packed {
        logic [3:0] distortion;
        logic [4:0] pitch;
        logic [7:0] frames;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            entry;
    } tbl_wr_t;

    typedef struct packed {
        logic [3:0]         distortion;
        logic [4:0]         pitch;
        logic [LEVEL_W-1:0] volume;
    } sound_t;

    typedef struct packed {
        sound_t melody;
        logic   melody_started;
        sound_t bass;
        logic   bass_started;
    } result_t;

endpackage

>>> hw/rtl/two_voice_note_sequencer.sv
// ============================================================================
// Two-voice note sequencer
// Melody and bass voices stepping through loadable note tables on frame ticks.
// ============================================================================
// Each accepted transaction yields exactly one result transaction. Loads,
// stops and ticks that start no note produce their result directly; play,
// and a tick on which a voice's countdown expires, produce it once the next
// note entry is read from the note table memory, whose read data is registered.
// The input is stalled while that read is pending. A two-entry output buffer
// lets the sequencer keep accepting while a result waits to be taken.
// Level registers should be written only while the sequencer is idle.
module two_voice_note_sequencer
    import tvns_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_data,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [1:0]             operation,
    input  logic                   voice,
    input  logic [5:0]             entry_index,
    input  logic [3:0]             entry_distortion,
    input  logic [4:0]             entry_pitch,
    input  logic [7:0]             entry_frames,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [3:0]             melody_distortion,
    output logic [4:0]             melody_pitch,
    output logic [3:0]             melody_volume,
    output logic                   melody_started,
    output logic [3:0]             bass_distortion,
    output logic [4:0]             bass_pitch,
    output logic [3:0]             bass_volume,
    output logic                   bass_started
);

    logic [LEVEL_W-1:0]    level_reg [NUM_VOICES];
    logic [ADDR_W-1:0]     pos_reg   [NUM_VOICES];
    logic [ADDR_W-1:0]     pos_next  [NUM_VOICES];
    logic [7:0]            cnt_reg   [NUM_VOICES];
    logic [7:0]            cnt_next  [NUM_VOICES];
    sound_t                snd_reg   [NUM_VOICES];
    sound_t                snd_next  [NUM_VOICES];
    logic [NUM_VOICES-1:0] pend_reg;
    logic [NUM_VOICES-1:0] pend_next;

    tbl_wr_t               tbl_wr    [NUM_VOICES];
    logic                  rd_en     [NUM_VOICES];
    logic [ADDR_W-1:0]     rd_addr   [NUM_VOICES];
    entry_t                rd_entry  [NUM_VOICES];
    entry_t                zero_entry[NUM_VOICES];

    result_t               out_reg;
    result_t               skid_reg;
    logic                  out_valid_reg;
    logic                  skid_valid_reg;

    logic                  accept;
    logic                  pop;
    logic                  push;
    result_t               push_data;
    op_t                   op;
    logic                  load_ok;
    logic [ADDR_W-1:0]     load_addr;

    assign op        = op_t'(operation);
    assign accept    = item_valid && !item_stall;
    assign pop       = out_valid_reg && !result_stall;
    assign load_ok   = int'(entry_index) < TABLE_DEPTH;
    assign load_addr = ADDR_W'(entry_index);

    assign item_stall = (|pend_reg) || skid_valid_reg;

    tvns_table u_melody_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (tbl_wr[VOICE_MELODY]),
        .rd_en      (rd_en[VOICE_MELODY]),
        .rd_addr    (rd_addr[VOICE_MELODY]),
        .rd_entry   (rd_entry[VOICE_MELODY]),
        .zero_entry (zero_entry[VOICE_MELODY])
    );

    tvns_table u_bass_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (tbl_wr[VOICE_BASS]),
        .rd_en      (rd_en[VOICE_BASS]),
        .rd_addr    (rd_addr[VOICE_BASS]),
        .rd_entry   (rd_entry[VOICE_BASS]),
        .zero_entry (zero_entry[VOICE_BASS])
    );

    always_comb
    begin
        entry_t            ent;
        logic [ADDR_W-1:0] pos_inc;
        ent     = '0;
        pos_inc = '0;
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            pos_next[v]  = pos_reg[v];
            cnt_next[v]  = cnt_reg[v];
            snd_next[v]  = snd_reg[v];
            pend_next[v] = 1'b0;
            rd_en[v]     = 1'b0;
            rd_addr[v]   = '0;
            tbl_wr[v].en    = 1'b0;
            tbl_wr[v].addr  = load_addr;
            tbl_wr[v].entry = '{distortion: entry_distortion, pitch: entry_pitch,
                                frames: entry_frames};

            if (pos_reg[v] == ADDR_W'(TABLE_DEPTH - 1))
            begin
                pos_inc = '0;
            end
            else
            begin
                pos_inc = pos_reg[v] + ADDR_W'(1);
            end

            if (pend_reg[v])
            begin
                // A zero-length entry marks the song end: restart from entry 0.
                if (rd_entry[v].frames != 8'd0)
                begin
                    ent = rd_entry[v];
                end
                else
                begin
                    ent         = zero_entry[v];
                    pos_next[v] = '0;
                end
                snd_next[v].distortion = ent.distortion;
                snd_next[v].pitch      = ent.pitch;
                snd_next[v].volume     = level_reg[v];
                cnt_next[v]            = ent.frames;
            end

            if (accept)
            begin
                case (op)
                    OP_TICK:
                    begin
                        if (cnt_reg[v] != 8'd0)
                        begin
                            cnt_next[v] = cnt_reg[v] - 8'd1;
                            if (cnt_reg[v] == 8'd1)
                            begin
                                pend_next[v] = 1'b1;
                                pos_next[v]  = pos_inc;
                                rd_en[v]     = 1'b1;
                                rd_addr[v]   = pos_inc;
                            end
                        end
                    end
                    OP_PLAY:
                    begin
                        pend_next[v] = 1'b1;
                        pos_next[v]  = '0;
                        rd_en[v]     = 1'b1;
                        rd_addr[v]   = '0;
                    end
                    OP_LOAD:
                    begin
                        tbl_wr[v].en = load_ok && (int'(voice) == v);
                    end
                    OP_STOP:
                    begin
                        pos_next[v] = '0;
                        cnt_next[v] = '0;
                        snd_next[v] = '0;
                    end
                    default:
                    begin
                        pend_next[v] = 1'b0;
                    end
                endcase
            end
        end
    end

    assign push = (accept && (pend_next == '0)) || (|pend_reg);

    always_comb
    begin
        push_data.melody         = snd_next[VOICE_MELODY];
        push_data.melody_started = pend_reg[VOICE_MELODY];
        push_data.bass           = snd_next[VOICE_BASS];
        push_data.bass_started   = pend_reg[VOICE_BASS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg[VOICE_MELODY] <= MELODY_LEVEL_RST;
            level_reg[VOICE_BASS]   <= BASS_LEVEL_RST;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                pos_reg[v] <= '0;
                cnt_reg[v] <= '0;
                snd_reg[v] <= '0;
            end
            pend_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MELODY_LEVEL: level_reg[VOICE_MELODY] <= cfg_data;
                    CFG_BASS_LEVEL:   level_reg[VOICE_BASS]   <= cfg_data;
                    default:          level_reg[VOICE_MELODY] <= level_reg[VOICE_MELODY];
                endcase
            end
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                pos_reg[v] <= pos_next[v];
                cnt_reg[v] <= cnt_next[v];
                snd_reg[v] <= snd_next[v];
            end
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_reg  <= skid_valid_reg || push;
                skid_valid_reg <= skid_valid_reg && push;
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            out_reg <= skid_valid_reg ? skid_reg : push_data;
            if (skid_valid_reg && push)
            begin
                skid_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign result_valid      = out_valid_reg;
    assign melody_distortion = out_reg.melody.distortion;
    assign melody_pitch      = out_reg.melody.pitch;
    assign melody_volume     = out_reg.melody.volume;
    assign melody_started    = out_reg.melody_started;
    assign bass_distortion   = out_reg.bass.distortion;
    assign bass_pitch        = out_reg.bass.pitch;
    assign bass_volume       = out_reg.bass.volume;
    assign bass_started      = out_reg.bass_started;

    a_pend_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (|pend_reg) |=> (pend_reg == '0))
        else $error("A note start stayed pending for more than one cycle.");

    a_pend_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (|pend_reg) |-> $past(accept))
        else $error("A note start is pending without an accepted transaction.");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("The skid stage holds a result while the output is empty.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && skid_valid_reg) |-> pop)
        else $error("A result was produced with both output stages full.");

endmodule

>>> hw/rtl/tvns_table.sv
// ============================================================================
// Note table
// One voice's note table: a synchronous memory with one write and one
// registered read port, per-entry valid bits so that unwritten entries read
// as zero, and a register copy of entry 0 for wrapping to the song start.
// ============================================================================
module tvns_table
    import tvns_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_wr_t           wr,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_entry,
    output entry_t            zero_entry
);

    entry_t                 mem [TABLE_DEPTH];
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    entry_t                 zero_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            zero_reg     <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
                if (wr.addr == '0)
                begin
                    zero_reg <= wr.entry;
                end
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry   = rd_valid_reg ? rd_data_reg : '0;
    assign zero_entry = zero_reg;

endmodule
